[src/vwbp_pkg.sv]
// Shared constants, codes and types for the variable-width bitfield packer.
package vwbp_pkg;

    localparam int MASK_BYTES     = 64;
    localparam int BYTE_W         = 8;
    localparam int IDX_W          = $clog2(MASK_BYTES);
    localparam int STORE_BITS     = MASK_BYTES * BYTE_W;
    localparam int CUR_W          = $clog2(STORE_BITS + 1);
    localparam int SUM_W          = CUR_W + 1;
    localparam int FLAG_BITS      = 2;
    localparam int MAX_FIELD_BITS = 32;
    localparam int DATA_W         = 32;
    localparam int WIDTH_W        = 6;
    localparam int LEN_W          = 7;
    localparam int STAT_W         = 2;
    localparam int REQ_W          = 2;
    localparam int SPAN_W         = MAX_FIELD_BITS + BYTE_W;
    localparam int SPAN_BYTES     = SPAN_W / BYTE_W;
    localparam int STEP_W         = $clog2(SPAN_BYTES);

    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD = 2'd0,
        REQ_PACK = 2'd1,
        REQ_READ = 2'd2
    } req_type_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_FORMAT   = 2'd1,
        STAT_OVERFLOW = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_MERGE
    } state_t;

endpackage

[src/vwbp_if.sv]
// Request and result channel interfaces of the bitfield packer.
interface vwbp_req_if;
    logic                                valid;
    logic                                ready;
    logic [vwbp_pkg::REQ_W-1:0]          req_type;
    logic [vwbp_pkg::IDX_W-1:0]          byte_index;
    logic [vwbp_pkg::BYTE_W-1:0]         byte_value;
    logic [vwbp_pkg::DATA_W-1:0]         field_value;
    logic [vwbp_pkg::WIDTH_W-1:0]        field_width;
    logic                                keep_old;
    logic                                last_field;

    modport source (
        output valid, req_type, byte_index, byte_value, field_value, field_width,
               keep_old, last_field,
        input  ready
    );
    modport sink (
        input  valid, req_type, byte_index, byte_value, field_value, field_width,
               keep_old, last_field,
        output ready
    );
endinterface

interface vwbp_res_if;
    logic                                valid;
    logic                                ready;
    logic [vwbp_pkg::BYTE_W-1:0]         read_data;
    logic [vwbp_pkg::STAT_W-1:0]         status;
    logic [vwbp_pkg::LEN_W-1:0]          packed_length;
    logic                                done_res;

    modport source (
        output valid, read_data, status, packed_length, done_res,
        input  ready
    );
    modport sink (
        input  valid, read_data, status, packed_length, done_res,
        output ready
    );
endinterface

[src/vwbp_align.sv]
// Aligns a field's value bits and write mask to its bit offset within the first byte.
module vwbp_align (
    input  logic [vwbp_pkg::DATA_W-1:0]  value,
    input  logic [vwbp_pkg::WIDTH_W-1:0] width,
    input  logic [2:0]                   offset,
    output logic [vwbp_pkg::SPAN_W-1:0]  data,
    output logic [vwbp_pkg::SPAN_W-1:0]  mask
);
    import vwbp_pkg::*;

    logic [DATA_W:0]   ones;
    logic [DATA_W-1:0] field_mask;

    // width is already clamped to 0..32; 2^width - 1 fits in DATA_W+1 bits
    assign ones       = ({{DATA_W{1'b0}}, 1'b1} << width) - {{DATA_W{1'b0}}, 1'b1};
    assign field_mask = ones[DATA_W-1:0];

    assign mask = {{(SPAN_W-DATA_W){1'b0}}, field_mask} << offset;
    assign data = {{(SPAN_W-DATA_W){1'b0}}, value & field_mask} << offset;

endmodule

[src/variable_width_bitfield_packer.sv]
// Top level of the variable-width bitfield packer: byte store, cursor state and RMW sequencer.
//
// Packs LSB-first variable-width fields into a 64-byte store held in one
// synchronous byte memory (one read, one write per cycle, registered read
// data). Packing of each mask starts at bit 2; bits 0 and 1 are flag bits
// that field writes never touch. One request is handled at a time and gives
// exactly one result transaction. A load and a field that writes nothing
// (keep, zero width, aborted mask or overflow) set the result register on
// acceptance; a read passes through S_READ; a written field that spans n
// store bytes (n = 1..5) passes through S_MERGE, one read-modify-write of
// the byte memory per touched byte. A new request is taken once the sequencer
// is idle and the result register is free or being drained. The store has
// no reset and no clearing pass: bytes must be loaded before they are read
// or merged into. Status is 0 ok, 1 zero-width format error (the rest of
// the mask is then rejected), 2 store overflow; the last field of a mask
// returns the cursor to bit 2 and, if ok, reports the packed length in bytes.
module variable_width_bitfield_packer (
    input  logic       clk,
    input  logic       rst_n,
    vwbp_req_if.sink   req,
    vwbp_res_if.source res
);
    import vwbp_pkg::*;

    // byte store
    logic [BYTE_W-1:0] store_mem [MASK_BYTES];
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic [BYTE_W-1:0] rd_data_reg;

    // sequencer and packing state
    state_t            state_reg, state_next;
    logic [CUR_W-1:0]  cursor_reg, cursor_next;
    logic [CUR_W-1:0]  wend_reg, wend_next;
    logic              abort_reg, abort_next;
    logic [IDX_W-1:0]  addr_reg, addr_next;
    logic [IDX_W-1:0]  end_reg, end_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [SPAN_W-1:0] algn_data_reg, algn_data_next;
    logic [SPAN_W-1:0] algn_mask_reg, algn_mask_next;

    // result register
    logic              res_valid_reg, res_valid_next;
    logic [BYTE_W-1:0] rdata_reg, rdata_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic [LEN_W-1:0]  plen_reg, plen_next;
    logic              done_reg, done_next;

    // request decode
    logic               accept;
    logic [WIDTH_W-1:0] width_clamped;
    logic [SUM_W-1:0]   field_end;
    logic [SUM_W-1:0]   field_last_bit;
    logic               overflow;
    logic [CUR_W-1:0]   wend_after;
    logic [SUM_W-1:0]   wend_round;
    logic [LEN_W-1:0]   plen_calc;
    logic [SPAN_W-1:0]  algn_data;
    logic [SPAN_W-1:0]  algn_mask;
    logic [BYTE_W-1:0]  byte_data;
    logic [BYTE_W-1:0]  byte_mask;
    logic [BYTE_W-1:0]  merged;

    assign req.ready = (state_reg == S_IDLE) && (!res_valid_reg || res.ready);
    assign accept    = req.valid && req.ready;

    assign width_clamped = (req.field_width > WIDTH_W'(MAX_FIELD_BITS))
                         ? WIDTH_W'(MAX_FIELD_BITS) : req.field_width;
    assign field_end      = {1'b0, cursor_reg} + SUM_W'(width_clamped);
    assign field_last_bit = field_end - SUM_W'(1);
    assign overflow       = field_end > SUM_W'(STORE_BITS);

    // length after a successful field: written end moves only on a write
    assign wend_after = req.keep_old ? wend_reg : field_end[CUR_W-1:0];
    assign wend_round = {1'b0, wend_after} + SUM_W'(BYTE_W - 1);
    assign plen_calc  = (wend_round[SUM_W-1:3] == '0) ? LEN_W'(1)
                                                      : LEN_W'(wend_round[SUM_W-1:3]);

    vwbp_align u_align (
        .value  (req.field_value),
        .width  (width_clamped),
        .offset (cursor_reg[2:0]),
        .data   (algn_data),
        .mask   (algn_mask)
    );

    // byte of the aligned field that lands in the byte under merge
    assign byte_data = BYTE_W'(algn_data_reg >> {step_reg, 3'b000});
    assign byte_mask = BYTE_W'(algn_mask_reg >> {step_reg, 3'b000});
    assign merged    = (rd_data_reg & ~byte_mask) | (byte_data & byte_mask);

    always_comb
    begin
        state_next     = state_reg;
        cursor_next    = cursor_reg;
        wend_next      = wend_reg;
        abort_next     = abort_reg;
        addr_next      = addr_reg;
        end_next       = end_reg;
        step_next      = step_reg;
        algn_data_next = algn_data_reg;
        algn_mask_next = algn_mask_reg;
        rdata_next     = rdata_reg;
        status_next    = status_reg;
        plen_next      = plen_reg;
        done_next      = done_reg;
        res_valid_next = res_valid_reg && !res.ready;
        wr_en          = 1'b0;
        wr_addr        = addr_reg;
        wr_data        = merged;
        rd_en          = 1'b0;
        rd_addr        = addr_reg + IDX_W'(1);

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    rdata_next  = '0;
                    status_next = STAT_OK;
                    plen_next   = '0;
                    done_next   = 1'b0;
                    case (req.req_type)
                        REQ_LOAD:
                        begin
                            wr_en          = 1'b1;
                            wr_addr        = req.byte_index;
                            wr_data        = req.byte_value;
                            res_valid_next = 1'b1;
                        end
                        REQ_READ:
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = req.byte_index;
                            state_next = S_READ;
                        end
                        REQ_PACK:
                        begin
                            res_valid_next = 1'b1;
                            if (abort_reg)
                            begin
                                status_next = STAT_FORMAT;
                            end
                            else if (width_clamped == '0)
                            begin
                                status_next = STAT_FORMAT;
                                abort_next  = 1'b1;
                            end
                            else if (overflow)
                            begin
                                status_next = STAT_OVERFLOW;
                                cursor_next = CUR_W'(STORE_BITS);
                            end
                            else
                            begin
                                cursor_next = field_end[CUR_W-1:0];
                                if (!req.keep_old)
                                begin
                                    // start the byte-by-byte RMW; result waits for it
                                    wend_next      = field_end[CUR_W-1:0];
                                    rd_en          = 1'b1;
                                    rd_addr        = cursor_reg[IDX_W+2:3];
                                    addr_next      = cursor_reg[IDX_W+2:3];
                                    end_next       = field_last_bit[IDX_W+2:3];
                                    step_next      = '0;
                                    algn_data_next = algn_data;
                                    algn_mask_next = algn_mask;
                                    res_valid_next = 1'b0;
                                    state_next     = S_MERGE;
                                end
                            end
                            if (req.last_field)
                            begin
                                done_next = 1'b1;
                                if (!abort_reg && width_clamped != '0 && !overflow)
                                    plen_next = plen_calc;
                                cursor_next = CUR_W'(FLAG_BITS);
                                wend_next   = '0;
                                abort_next  = 1'b0;
                            end
                        end
                        default:
                        begin
                            res_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                rdata_next     = rd_data_reg;
                res_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            S_MERGE:
            begin
                wr_en = 1'b1;
                if (addr_reg == end_reg)
                begin
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    // next byte read overlaps this write; addresses differ
                    rd_en     = 1'b1;
                    addr_next = addr_reg + IDX_W'(1);
                    step_next = step_reg + STEP_W'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cursor_reg    <= CUR_W'(FLAG_BITS);
            wend_reg      <= '0;
            abort_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cursor_reg    <= cursor_next;
            wend_reg      <= wend_next;
            abort_reg     <= abort_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg      <= addr_next;
        end_reg       <= end_next;
        step_reg      <= step_next;
        algn_data_reg <= algn_data_next;
        algn_mask_reg <= algn_mask_next;
        rdata_reg     <= rdata_next;
        status_reg    <= status_next;
        plen_reg      <= plen_next;
        done_reg      <= done_next;
    end

    // store: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
            store_mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= store_mem[rd_addr];
    end

    assign res.valid         = res_valid_reg;
    assign res.read_data     = rdata_reg;
    assign res.status        = status_reg;
    assign res.packed_length = plen_reg;
    assign res.done_res      = done_reg;

endmodule

[sim/testbench.sv]
// Self-checking testbench for the variable-width bitfield packer.
`timescale 1ns / 100ps

module testbench;
    import vwbp_pkg::*;

    // Request type 3 is not decoded by the block; it must come back all zero.
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int ITEM_TARGET = 1350;
    localparam int TAIL_CYCLES = 20;

    typedef struct {
        logic [REQ_W-1:0]   req_type;
        logic [IDX_W-1:0]   byte_index;
        logic [BYTE_W-1:0]  byte_value;
        logic [DATA_W-1:0]  field_value;
        logic [WIDTH_W-1:0] field_width;
        logic               keep_old;
        logic               last_field;
    } packer_request_t;

    typedef struct {
        logic [BYTE_W-1:0] read_data;
        status_t           status;
        logic [LEN_W-1:0]  packed_length;
        logic              done_res;
    } packer_result_t;

    logic clk = 1'b0;
    logic rst_n;

    vwbp_req_if req_if ();
    vwbp_res_if res_if ();

    variable_width_bitfield_packer dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .res   (res_if)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Shadow of the packer: store contents, which bytes hold defined data,
    // and the per-mask cursor state. Updated when a request transaction is
    // accepted, so it always reflects the block as of the last acceptance.
    // ------------------------------------------------------------------
    logic [BYTE_W-1:0] shadow_store [MASK_BYTES];
    bit                byte_loaded  [MASK_BYTES];
    bit [CUR_W-1:0]    pack_cursor  = FLAG_BITS;
    bit [CUR_W-1:0]    written_end  = '0;
    bit                mask_aborted = 1'b0;

    packer_result_t pending_results [$];
    int error_count  = 0;
    int results_seen = 0;
    int items_sent   = 0;
    int burst_left   = 0;

    // Receiver stall generator state
    int       stall_mode  = 0;
    int       stall_timer = 0;
    bit [7:0] stall_pattern = 8'hff;

    // Applies one accepted request to the shadow and returns what the block
    // must answer with.
    function automatic packer_result_t pack_and_predict(packer_request_t rq);
        packer_result_t r;
        int unsigned    w;
        int unsigned    pos;
        int unsigned    nbytes;
        r.read_data     = '0;
        r.status        = STAT_OK;
        r.packed_length = '0;
        r.done_res      = 1'b0;
        case (rq.req_type)
            REQ_LOAD:
            begin
                shadow_store[rq.byte_index] = rq.byte_value;
                byte_loaded[rq.byte_index]  = 1'b1;
            end
            REQ_READ:
            begin
                r.read_data = shadow_store[rq.byte_index];
            end
            REQ_PACK:
            begin
                w = (rq.field_width > MAX_FIELD_BITS) ? MAX_FIELD_BITS : rq.field_width;
                if (mask_aborted)
                begin
                    r.status = STAT_FORMAT;
                end
                else if (w == 0)
                begin
                    r.status     = STAT_FORMAT;
                    mask_aborted = 1'b1;
                end
                else if (pack_cursor + w > STORE_BITS)
                begin
                    // cursor pins to the store end, so every later nonzero-width field of the mask overflows too
                    r.status    = STAT_OVERFLOW;
                    pack_cursor = STORE_BITS;
                end
                else
                begin
                    if (!rq.keep_old)
                    begin
                        for (int k = 0; k < w; k++)
                        begin
                            pos = pack_cursor + k;
                            shadow_store[pos >> 3][pos & 7] = rq.field_value[k];
                        end
                        written_end = pack_cursor + w;
                    end
                    pack_cursor = pack_cursor + w;
                end
                if (rq.last_field)
                begin
                    r.done_res = 1'b1;
                    if (r.status == STAT_OK)
                    begin
                        nbytes = (written_end + 7) >> 3;
                        r.packed_length = (nbytes == 0) ? 1 : nbytes;
                    end
                    pack_cursor  = FLAG_BITS;
                    written_end  = '0;
                    mask_aborted = 1'b0;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("[%0t] result %0d: %s got %0d expected %0d",
                 $time, results_seen, what, got, want);
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // Result checker: every result transaction is matched in order against
    // the oldest pending prediction.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_results
        packer_result_t want;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("transaction with nothing pending, status",
                                res_if.status, 0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (res_if.read_data !== want.read_data)
                    report_mismatch("read_data", res_if.read_data, want.read_data);
                if (res_if.status !== want.status)
                    report_mismatch("status", res_if.status, want.status);
                if (res_if.packed_length !== want.packed_length)
                    report_mismatch("packed_length", res_if.packed_length,
                                    want.packed_length);
                if (res_if.done_res !== want.done_res)
                    report_mismatch("done_res", res_if.done_res, want.done_res);
            end
            results_seen++;
        end
    end

    // ------------------------------------------------------------------
    // Receiver back-pressure. The mode is redrawn whenever its random timer runs out:
    // always ready, mostly ready, a rotating 8-bit pattern, or long stalls.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (stall_timer == 0)
        begin
            stall_mode    <= $urandom_range(0, 3);
            stall_timer   <= $urandom_range(50, 300);
            stall_pattern <= $urandom_range(1, 255);
        end
        else
        begin
            stall_timer <= stall_timer - 1;
        end
        case (stall_mode)
            0:       res_if.ready <= 1'b1;
            1:       res_if.ready <= ($urandom_range(0, 3) != 0);
            2:       res_if.ready <= stall_pattern[stall_timer % 8];
            default: res_if.ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Load request with every other field randomized; callers override what matters.
    function automatic packer_request_t random_request();
        packer_request_t rq;
        rq.req_type    = REQ_LOAD;
        rq.byte_index  = $urandom_range(0, MASK_BYTES - 1);
        rq.byte_value  = $urandom_range(0, 255);
        rq.field_value = $urandom;
        rq.field_width = $urandom_range(0, 63);
        rq.keep_old    = $urandom_range(0, 1);
        rq.last_field  = $urandom_range(0, 1);
        return rq;
    endfunction

    function automatic int unsigned pick_width();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(MAX_FIELD_BITS + 1, 63);
        return $urandom_range(1, MAX_FIELD_BITS);
    endfunction

    // Sends one request transaction. Called at a falling edge and returns at
    // a falling edge. The sender runs in bursts: valid stays high between
    // requests of a burst, and drops for a random gap when the burst ends.
    task automatic send_request(input packer_request_t rq);
        req_if.valid       <= 1'b1;
        req_if.req_type    <= rq.req_type;
        req_if.byte_index  <= rq.byte_index;
        req_if.byte_value  <= rq.byte_value;
        req_if.field_value <= rq.field_value;
        req_if.field_width <= rq.field_width;
        req_if.keep_old    <= rq.keep_old;
        req_if.last_field  <= rq.last_field;
        do
            @(posedge clk);
        while (!req_if.ready);
        pending_results.push_back(pack_and_predict(rq));
        if (rq.req_type != REQ_UNUSED)
            items_sent++;
        @(negedge clk);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
    endtask

    // Sender holds off until every outstanding result has come back.
    task automatic hold_until_drained();
        req_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        burst_left = $urandom_range(1, 12);
    endtask

    task automatic load_byte(input int unsigned idx, input int unsigned value);
        packer_request_t rq;
        rq            = random_request();
        rq.req_type   = REQ_LOAD;
        rq.byte_index = idx;
        rq.byte_value = value;
        send_request(rq);
    endtask

    // Store bytes hold no defined value until loaded, so a read of a fresh
    // byte is preceded by a load of it.
    task automatic read_byte(input int unsigned idx);
        packer_request_t rq;
        if (!byte_loaded[idx])
            load_byte(idx, $urandom_range(0, 255));
        rq            = random_request();
        rq.req_type   = REQ_READ;
        rq.byte_index = idx;
        send_request(rq);
    endtask

    // One field of a mask. A field that will really be written merges into
    // every byte it touches, so those bytes get loaded first if still fresh.
    task automatic pack_field(input int unsigned width, input logic [DATA_W-1:0] value,
                              input bit keep, input bit last);
        packer_request_t rq;
        int unsigned     wc;
        rq             = random_request();
        rq.req_type    = REQ_PACK;
        rq.field_width = width;
        rq.field_value = value;
        rq.keep_old    = keep;
        rq.last_field  = last;
        wc = (width > MAX_FIELD_BITS) ? MAX_FIELD_BITS : width;
        if (!mask_aborted && wc != 0 && !keep && pack_cursor + wc <= STORE_BITS)
        begin
            for (int unsigned b = pack_cursor >> 3; b <= (pack_cursor + wc - 1) >> 3; b++)
            begin
                if (!byte_loaded[b])
                    load_byte(b, $urandom_range(0, 255));
            end
        end
        send_request(rq);
    endtask

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    // Loads and reads at both ends of the store, plus the undecoded type.
    task automatic test_store_access();
        packer_request_t rq;
        load_byte(0, 8'hff);
        load_byte(MASK_BYTES - 1, 8'h00);
        load_byte(5, 8'ha5);
        read_byte(0);
        read_byte(MASK_BYTES - 1);
        read_byte(5);
        rq          = random_request();
        rq.req_type = REQ_UNUSED;
        send_request(rq);
    endtask

    // Narrowest and widest fields, an exact byte-end, keep fields carrying
    // the cursor across bytes, an over-wide width, and flag-bit preservation
    // in byte 0 (loaded all ones above).
    task automatic test_field_extremes();
        pack_field(1, 32'h0, 1'b0, 1'b0);
        pack_field(5, 32'h1f, 1'b0, 1'b0);           // ends exactly at bit 8
        pack_field(MAX_FIELD_BITS, 32'h0, 1'b1, 1'b0);
        pack_field(MAX_FIELD_BITS, 32'hffff_ffff, 1'b0, 1'b0);
        pack_field(63, 32'h0, 1'b0, 1'b1);            // clamped to 32 bits
        read_byte(0);
        pack_field(10, $urandom, 1'b1, 1'b1);         // keep-only mask: length 1
    endtask

    // Zero width aborts the rest of the mask; the next mask starts clean.
    task automatic test_format_error();
        pack_field(0, $urandom, 1'b0, 1'b0);
        pack_field(8, $urandom, 1'b0, 1'b0);
        pack_field(4, $urandom, 1'b0, 1'b1);
        pack_field(0, $urandom, 1'b0, 1'b1);
        pack_field(3, 32'h5, 1'b0, 1'b1);
    endtask

    // ------------------------------------------------------------------
    // Random sequences
    // ------------------------------------------------------------------

    task automatic run_short_mask();
        int n;
        n = $urandom_range(1, 10);
        for (int i = 0; i < n; i++)
            pack_field(pick_width(), $urandom, ($urandom_range(0, 3) == 0), (i == n - 1));
    endtask

    // Runs the cursor up to the store end: either fills it exactly (length
    // 64) or overshoots and keeps going so the overflow sticks.
    task automatic run_long_mask();
        int unsigned room;
        room = STORE_BITS - pack_cursor;
        for (int i = 0; i < 24 && room > MAX_FIELD_BITS; i++)
        begin
            pack_field($urandom_range(12, MAX_FIELD_BITS), $urandom,
                       ($urandom_range(0, 3) != 0), 1'b0);
            room = STORE_BITS - pack_cursor;
        end
        if (room != 0 && $urandom_range(0, 1) == 0)
        begin
            pack_field(room, $urandom, 1'b0, 1'b1);
        end
        else
        begin
            pack_field(room + $urandom_range(1, 8), $urandom, $urandom_range(0, 1), 1'b0);
            pack_field(pick_width(), $urandom, $urandom_range(0, 1), 1'b1);
        end
    endtask

    // Malformed masks: zero widths anywhere, and sometimes no closing field,
    // so the mask carries into whatever comes next.
    task automatic run_broken_mask();
        int n;
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
            pack_field(($urandom_range(0, 9) < 3) ? 0 : pick_width(), $urandom,
                       $urandom_range(0, 1), (i == n - 1) && $urandom_range(0, 1));
    endtask

    task automatic test_random_traffic();
        packer_request_t rq;
        int sel;
        while (items_sent < ITEM_TARGET)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 55)
                run_short_mask();
            else if (sel < 67)
                run_long_mask();
            else if (sel < 77)
                run_broken_mask();
            else if (sel < 86)
                load_byte($urandom_range(0, MASK_BYTES - 1), $urandom_range(0, 255));
            else if (sel < 96)
                read_byte($urandom_range(0, MASK_BYTES - 1));
            else if (sel < 98)
            begin
                rq          = random_request();
                rq.req_type = REQ_UNUSED;
                send_request(rq);
            end
            else
                hold_until_drained();
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n              = 1'b0;
        req_if.valid       = 1'b0;
        req_if.req_type    = REQ_LOAD;
        req_if.byte_index  = '0;
        req_if.byte_value  = '0;
        req_if.field_value = '0;
        req_if.field_width = '0;
        req_if.keep_old    = 1'b0;
        req_if.last_field  = 1'b0;
        burst_left         = $urandom_range(1, 12);
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_store_access();
        test_field_extremes();
        test_format_error();
        hold_until_drained();
        test_random_traffic();
        hold_until_drained();
        // run an idle tail to catch any stray result transaction
        repeat (TAIL_CYCLES) @(negedge clk);

        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run of this stimulus.
    initial
    begin
        #5000000;
        $display("timeout with %0d results pending", pending_results.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
